// ----- hw/rtl/stable_priority_queue_defines.svh -----
// Assertion macros shared by the priority queue RTL.
// Included by the files that carry concurrent checks; needs clk and rst in scope.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Check that holds at every edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition at one edge implies a consequence at the next.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
// Package for the stable priority queue: parameter defaults, request and
// status codes, and the command struct sent to every cell. No dependencies.
package spq_pkg;

  localparam int DEPTH_DEFAULT         = 16;
  localparam int PRIORITY_BITS_DEFAULT = 8;
  localparam int TAG_BITS_DEFAULT      = 16;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds a priority, a tag and a valid bit.
// Depends on spq_pkg for the command struct.
module spq_cell #(
  parameter int PRIORITY_BITS = 8,
  parameter int TAG_BITS      = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spq_pkg::cell_cmd_t       cmd,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic                     left_valid,
  input  logic                     left_ahead,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]      right_tag,
  output logic                     valid,
  output logic                     ahead,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]      tag
);
  import spq_pkg::*;

  logic                     valid_next;
  logic [PRIORITY_BITS-1:0] prio_next;
  logic [TAG_BITS-1:0]      tag_next;

  // Entry stays in front of a new word of equal or higher priority value.
  assign ahead = valid && (prio <= new_prio);

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    tag_next   = tag;
    if (cmd.enq) begin
      valid_next = valid | left_valid;
      if (!ahead) begin
        if (left_ahead) begin
          prio_next = new_prio;
          tag_next  = new_tag;
        end else begin
          prio_next = left_prio;
          tag_next  = left_tag;
        end
      end
    end else if (cmd.deq) begin
      // advance everything one slot towards the front
      valid_next = right_valid;
      prio_next  = right_prio;
      tag_next   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    tag  <= tag_next;
  end

endmodule

// ----- hw/rtl/stable_priority_queue.sv -----
// Stable bounded priority queue built as a shifting chain of compare cells.
// Depends on spq_pkg, spq_cell and stable_priority_queue_defines.svh.
//
//   channel | handshake            | words
//   --------+----------------------+------------------------------
//   in      | in_valid / in_stall  | mode, priority_req, tag
//   out     | out_valid / out_stall| status, tag_out, count
//
// One request per cycle while in_stall is low: every cell compares and shifts
// in the same cycle, and the result is registered on acceptance. in_stall is
// high while a result waits in the output register and out_stall holds it.
// Reset empties every cell and the output register; no clearing pass.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [PRIORITY_BITS-1:0]       priority_req,
  input  logic [TAG_BITS-1:0]            tag,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [TAG_BITS-1:0]            tag_out,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                     accept;
  logic                     full;
  logic                     empty;
  cell_cmd_t                cmd;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  status_t                  status_next;
  logic [TAG_BITS-1:0]      tag_out_next;

  logic [DEPTH-1:0]         c_valid;
  logic [DEPTH-1:0]         c_ahead;
  logic [PRIORITY_BITS-1:0] c_prio [DEPTH];
  logic [TAG_BITS-1:0]      c_tag  [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt == CNT_W'(DEPTH));
  assign empty    = (cnt == '0);

  always_comb begin
    cmd.enq      = 1'b0;
    cmd.deq      = 1'b0;
    cnt_next     = cnt;
    tag_out_next = '0;
    if (mode == MODE_ENQ) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ENQ;
        cmd.enq     = accept;
        cnt_next    = cnt + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next  = ST_DEQ;
        cmd.deq      = accept;
        tag_out_next = c_tag[0];
        cnt_next     = cnt - 1'b1;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                     l_valid;
      logic                     l_ahead;
      logic [PRIORITY_BITS-1:0] l_prio;
      logic [TAG_BITS-1:0]      l_tag;
      logic                     r_valid;
      logic [PRIORITY_BITS-1:0] r_prio;
      logic [TAG_BITS-1:0]      r_tag;

      if (i == 0) begin : g_head
        // front cell sees the new word as its left neighbour
        assign l_valid = 1'b1;
        assign l_ahead = 1'b1;
        assign l_prio  = priority_req;
        assign l_tag   = tag;
      end else begin : g_body
        assign l_valid = c_valid[i-1];
        assign l_ahead = c_ahead[i-1];
        assign l_prio  = c_prio[i-1];
        assign l_tag   = c_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_prio  = c_prio[i];
        assign r_tag   = c_tag[i];
      end else begin : g_mid
        assign r_valid = c_valid[i+1];
        assign r_prio  = c_prio[i+1];
        assign r_tag   = c_tag[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS(PRIORITY_BITS),
        .TAG_BITS     (TAG_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .new_prio   (priority_req),
        .new_tag    (tag),
        .left_valid (l_valid),
        .left_ahead (l_ahead),
        .left_prio  (l_prio),
        .left_tag   (l_tag),
        .right_valid(r_valid),
        .right_prio (r_prio),
        .right_tag  (r_tag),
        .valid      (c_valid[i]),
        .ahead      (c_ahead[i]),
        .prio       (c_prio[i]),
        .tag        (c_tag[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result word while it is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= status_next;
      tag_out <= tag_out_next;
      count   <= cnt_next;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_fill, $countones(c_valid) == cnt, "cell fill differs from count")
  `SPQ_ASSERT_ALWAYS(a_count_bound, cnt <= CNT_W'(DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_enq_grows, cmd.enq, cnt == $past(cnt) + 1'b1, "enqueue did not grow count")
  `SPQ_ASSERT_NEXT(a_deq_front, cmd.deq, tag_out == $past(c_tag[0]), "dequeue lost front word")
  `SPQ_ASSERT_NEXT(a_deq_status, cmd.deq, status == ST_DEQ, "dequeue status wrong")

endmodule

// ----- tb/sv/spq_checker.sv -----
// Checker for the stable priority queue: watches both channels, keeps its own sorted copy
// of the queue contents and compares every result word against it.
// Depends on spq_pkg only.
module spq_checker (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic                                         in_stall,
  input  logic                                         mode,
  input  logic [spq_pkg::PRIORITY_BITS_DEFAULT-1:0]    priority_req,
  input  logic [spq_pkg::TAG_BITS_DEFAULT-1:0]         tag,
  input  logic                                         out_valid,
  input  logic                                         out_stall,
  input  logic [1:0]                                   status,
  input  logic [spq_pkg::TAG_BITS_DEFAULT-1:0]         tag_out,
  input  logic [$clog2(spq_pkg::DEPTH_DEFAULT+1)-1:0]  count,
  output int                                           errors,
  output int                                           outstanding
);
  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int PB    = PRIORITY_BITS_DEFAULT;
  localparam int TB    = TAG_BITS_DEFAULT;
  localparam int CB    = $clog2(DEPTH_DEFAULT + 1);

  typedef struct {
    status_t       st;
    logic [TB-1:0] tag;
    logic [CB-1:0] cnt;
  } queue_result_t;

  // entries held in service order at 0..fill-1
  logic [PB-1:0]  held_prio [DEPTH];
  logic [TB-1:0]  held_tag  [DEPTH];
  int             fill;
  queue_result_t  awaited_results [$];

  function automatic queue_result_t serve_request(logic m, logic [PB-1:0] p, logic [TB-1:0] t);
    queue_result_t r;
    int            pos;
    r.tag = '0;
    if (m == MODE_ENQ) begin
      if (fill >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        // go behind every stored entry of equal or lower value
        pos = 0;
        while (pos < fill && held_prio[pos] <= p) pos++;
        for (int i = fill; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_prio[pos] = p;
        held_tag[pos]  = t;
        fill++;
        r.st = ST_ENQ;
      end
    end else if (fill == 0) begin
      r.st = ST_EMPTY;
    end else begin
      r.tag = held_tag[0];
      for (int i = 0; i + 1 < fill; i++) begin
        held_prio[i] = held_prio[i+1];
        held_tag[i]  = held_tag[i+1];
      end
      fill--;
      r.st = ST_DEQ;
    end
    r.cnt = CB'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      fill = 0;
      awaited_results.delete();
    end else begin
      // retire the result word first: it belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word status %0d tag_out %h count %0d",
                   $time, status, tag_out, count);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
          end
          if (tag_out !== want.tag) begin
            errors++;
            $display("%0t: tag_out expected %h got %h", $time, want.tag, tag_out);
          end
          if (count !== want.cnt) begin
            errors++;
            $display("%0t: count expected %0d got %0d", $time, want.cnt, count);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(serve_request(mode, priority_req, tag));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ----- tb/sv/tb_stable_priority_queue.sv -----
// Top of the stable priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on spq_pkg, stable_priority_queue and spq_checker.
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int PB = PRIORITY_BITS_DEFAULT;
  localparam int TB = TAG_BITS_DEFAULT;
  localparam int CB = $clog2(DEPTH_DEFAULT + 1);
  localparam int RANDOM_PER_PHASE = 157;

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic          mode;
  logic [PB-1:0] priority_req;
  logic [TB-1:0] tag;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    status;
  logic [TB-1:0] tag_out;
  logic [CB-1:0] count;
  int            errors;
  int            outstanding;
  int            idle_pct  = 0;
  int            stall_pct = 0;

  always #6 clk = ~clk;

  stable_priority_queue uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .priority_req (priority_req),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tag_out      (tag_out),
    .count        (count)
  );

  spq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .priority_req (priority_req),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tag_out      (tag_out),
    .count        (count),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // present one request word, idling first at random, and hold it until taken
  task automatic send_request(input logic m, input logic [PB-1:0] p, input logic [TB-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    priority_req <= p;
    tag          <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // bunch priorities at both ends so that equal values are common
  function automatic logic [PB-1:0] pick_priority();
    logic [PB-1:0] p;
    case ($urandom_range(0, 3))
      0:       p = PB'($urandom);
      1:       p = PB'($urandom_range(0, 3));
      2:       p = PB'($urandom_range(252, 255));
      default: p = PB'($urandom_range(0, 15));
    endcase
    return p;
  endfunction

  initial begin
    int burst_left;
    int enq_pct;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= MODE_ENQ;
    priority_req <= '0;
    tag          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty on dequeue, fill with extremes and equal priorities, overfill, then dequeue four and enqueue one
    send_request(MODE_DEQ, '1, '1);
    for (int i = 0; i < DEPTH_DEFAULT; i++)
      send_request(MODE_ENQ, (i % 4 == 0) ? PB'(255) : (i % 4 == 1) ? PB'(0) : PB'(5),
                   TB'(i * 16'h1111));
    send_request(MODE_ENQ, '0, '1);
    repeat (4) send_request(MODE_DEQ, '0, '0);
    send_request(MODE_ENQ, PB'(5), 16'hA5A5);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      burst_left = 0;
      enq_pct    = 50;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // swing between filling and draining so full and empty both come round
        if (burst_left == 0) begin
          burst_left = $urandom_range(8, 40);
          case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
          endcase
        end
        burst_left--;
        send_request(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                     pick_priority(), TB'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_stable_priority_queue: done, clean");
    end else begin
      $display("tb_stable_priority_queue: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_stable_priority_queue: done, errors");
    $finish;
  end

endmodule
